// ===== rtl/core/rrlc_pkg.sv =====
// Shared types, wiring tables and modular helpers for the rotor/reflector
// letter cipher. No dependencies; used by rrlc_cfg and the top level.
package rrlc_pkg;

  localparam int unsigned Letters = 26;
  localparam logic [7:0] LETTER_A = 8'd65;
  localparam logic [7:0] LOWER_A  = 8'd97;
  localparam logic [7:0] LOWER_Z  = 8'd122;
  localparam logic [7:0] UPPER_Z  = 8'd90;
  localparam logic [7:0] CASE_GAP = 8'd32;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DOT   = 8'd46;

  typedef logic [4:0] letter_t;
  typedef letter_t tab_t [26];

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RIGHT  = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_LEFT   = 2'd2
  } reg_idx_e;

  // Rotor start offsets, always held reduced below 26
  typedef struct packed {
    letter_t right;
    letter_t middle;
    letter_t left;
  } offsets_t;

  // One item in flight through the pipeline
  typedef struct packed {
    logic       letter;
    logic       invalid;
    logic [7:0] pass_char;
    letter_t    x;
  } item_t;

  localparam tab_t PLUG_TAB = '{25, 15, 7, 13, 12, 18, 22, 2, 8, 24, 19, 16, 4,
                                3, 14, 1, 11, 17, 5, 10, 20, 21, 6, 23, 9, 0};
  localparam tab_t RIGHT_TAB = '{10, 12, 19, 5, 14, 8, 23, 22, 21, 20, 1, 0, 16,
                                 15, 13, 24, 4, 2, 17, 9, 18, 11, 25, 7, 6, 3};
  localparam tab_t MIDDLE_TAB = '{21, 25, 24, 23, 22, 20, 19, 18, 17, 16, 15, 14, 13,
                                  12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0};
  localparam tab_t LEFT_TAB = '{0, 9, 3, 10, 18, 8, 17, 20, 23, 1, 11, 7, 22,
                                19, 12, 2, 16, 6, 25, 13, 15, 24, 5, 21, 14, 4};
  localparam tab_t REFLECT_TAB = '{24, 17, 20, 7, 16, 18, 11, 3, 15, 23, 13, 6, 14,
                                   10, 12, 8, 4, 1, 5, 25, 2, 22, 21, 9, 0, 19};

  // Build the inverse permutation of a wiring table
  function automatic tab_t tab_invert(input tab_t t);
    tab_t r;
    r = '{default: '0};
    for (int i = 0; i < Letters; i++) begin
      r[t[i]] = letter_t'(i);
    end
    return r;
  endfunction

  localparam tab_t PLUG_INV   = tab_invert(PLUG_TAB);
  localparam tab_t RIGHT_INV  = tab_invert(RIGHT_TAB);
  localparam tab_t MIDDLE_INV = tab_invert(MIDDLE_TAB);
  localparam tab_t LEFT_INV   = tab_invert(LEFT_TAB);

  // (a - b) mod 26 for a, b below 26
  function automatic letter_t sub_mod(input letter_t a, input letter_t b);
    logic [5:0] t;
    t = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + 6'(Letters) - {1'b0, b};
    return t[4:0];
  endfunction

  // (a + b) mod 26 for a, b below 26
  function automatic letter_t add_mod(input letter_t a, input letter_t b);
    logic [5:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= 6'(Letters)) begin
      t = t - 6'(Letters);
    end
    return t[4:0];
  endfunction

  // Forward pass through a rotor at a given start offset
  function automatic letter_t rot_fwd(input tab_t t, input letter_t x, input letter_t s);
    return t[sub_mod(x, s)];
  endfunction

  // Return pass through a rotor, given its inverse table
  function automatic letter_t rot_back(input tab_t inv, input letter_t x, input letter_t s);
    return add_mod(inv[x], s);
  endfunction

endpackage

// ===== rtl/core/rrlc_cfg.sv =====
// Rotor start offset registers for the letter cipher.
// Depends on rrlc_pkg; reduces each written value mod 26 on the way in.
module rrlc_cfg
  import rrlc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  output offsets_t   offsets_o
);

  offsets_t offsets_q, offsets_d;
  letter_t  data_red;

  // Fold values 26..31 back into range
  assign data_red = (cfg_data_i >= 5'(Letters)) ? cfg_data_i - 5'(Letters) : cfg_data_i;

  // Steer the write to the addressed offset, drop unknown indexes
  always_comb begin
    offsets_d = offsets_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RIGHT:  offsets_d.right  = data_red;
        REG_MIDDLE: offsets_d.middle = data_red;
        REG_LEFT:   offsets_d.left   = data_red;
        default:    offsets_d = offsets_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
    end else begin
      offsets_q <= offsets_d;
    end
  end

  assign offsets_o = offsets_q;

endmodule

// ===== rtl/core/rotor_reflector_letter_cipher_top.sv =====
// Top level of the rotor/reflector letter cipher: five-stage table pipeline.
// Depends on rrlc_pkg and rrlc_cfg.
// An accepted request moves through stage registers 0 to 4; done_o is the valid bit of the last stage.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset: asynchronous, active low; clears valid bits and offsets (all zero).
module rotor_reflector_letter_cipher_top
  import rrlc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_in_i,
  output logic       done_o,
  output logic [7:0] char_out_o,
  output logic       invalid_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned Stages = 5;

  offsets_t off;
  logic     accept;

  item_t s0_d;
  item_t stage_q [Stages];
  item_t stage_d [Stages];
  logic [Stages-1:0] valid_q;
  logic [7:0] folded;

  rrlc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .offsets_o (off)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode: fold case, classify, plugboard
  always_comb begin
    folded = char_in_i;
    if (char_in_i >= LOWER_A && char_in_i <= LOWER_Z) begin
      folded = char_in_i - CASE_GAP;
    end
    s0_d = '0;
    if (folded == CHAR_SPACE) begin
      s0_d.pass_char = CHAR_DOT;
    end else if (folded == CHAR_DOT) begin
      s0_d.pass_char = CHAR_SPACE;
    end else if (folded >= LETTER_A && folded <= UPPER_Z) begin
      s0_d.letter = 1'b1;
      s0_d.x      = PLUG_TAB[5'(folded - LETTER_A)];
    end else begin
      s0_d.invalid   = 1'b1;
      s0_d.pass_char = char_in_i;
    end
  end

  // Stage logic: right+middle, left+reflector, back left+middle, back right+plug
  always_comb begin
    stage_d[0] = s0_d;
    for (int i = 1; i < Stages; i++) begin
      stage_d[i] = stage_q[i-1];
    end
    stage_d[1].x = rot_fwd(MIDDLE_TAB, rot_fwd(RIGHT_TAB, stage_q[0].x, off.right),
                           off.middle);
    stage_d[2].x = REFLECT_TAB[rot_fwd(LEFT_TAB, stage_q[1].x, off.left)];
    stage_d[3].x = rot_back(MIDDLE_INV, rot_back(LEFT_INV, stage_q[2].x, off.left),
                            off.middle);
    stage_d[4].x = PLUG_INV[rot_back(RIGHT_INV, stage_q[3].x, off.right)];
  end

  // Advance valid bits every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], accept};
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Stages; i++) begin
      stage_q[i] <= stage_d[i];
    end
  end

  // Drive the result
  assign done_o     = valid_q[Stages-1];
  assign invalid_o  = stage_q[Stages-1].invalid;
  assign char_out_o = stage_q[Stages-1].letter ?
                      ({3'b000, stage_q[Stages-1].x} + LETTER_A) :
                      stage_q[Stages-1].pass_char;

  // Every request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("request did not produce a result");

  // Space maps to dot
  a_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && char_in_i == CHAR_SPACE) |-> ##5 (char_out_o == CHAR_DOT && !invalid_o))
    else $error("space not mapped to dot");

  // Valid results are upper-case letters, space or dot
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !invalid_o) |-> ((char_out_o >= LETTER_A && char_out_o <= UPPER_Z) ||
                                char_out_o == CHAR_SPACE || char_out_o == CHAR_DOT))
    else $error("valid result outside letter set");

  // Offsets stay reduced
  a_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off.right < 5'(Letters)) && (off.middle < 5'(Letters)) && (off.left < 5'(Letters)))
    else $error("rotor offset out of range");

endmodule
